/* sv/grt_pkg.sv */
// Shared types and constants for the group reverse transposer.
`timescale 1ns / 1ps

package grt_pkg;

  localparam int DATA_W = 8;
  localparam int SIZE_W = 6;
  localparam int CMP_W  = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] GROUP_SIZE_RESET = SIZE_W'(4);

  // register index, taken from paddr[2]
  localparam logic REG_GROUP_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_FILL = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic dec_ptr;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_ready;
    logic group_done;
    logic ptr_zero;
  } status_t;

endpackage

/* sv/grt_in_if.sv */
// Input channel: one character of a line with its line-end flag.
`timescale 1ns / 1ps

interface grt_in_if;
  logic                     valid;
  logic                     ready;
  logic [grt_pkg::DATA_W-1:0] char_in;
  logic                     line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

/* sv/grt_out_if.sv */
// Output channel: one character of the transposed line with its flags.
`timescale 1ns / 1ps

interface grt_out_if;
  logic                     valid;
  logic                     ready;
  logic [grt_pkg::DATA_W-1:0] char_out;
  logic                     line_end_out;
  logic                     group_last;

  modport source (output valid, output char_out, output line_end_out, output group_last,
                  input ready);
  modport sink   (input valid, input char_out, input line_end_out, input group_last,
                  output ready);
endinterface

/* sv/grt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module grt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/grt_ctrl.sv */
// Controller: sequences group fill, per-character read and output transfer.
`timescale 1ns / 1ps

module grt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  grt_pkg::status_t sts,
  output grt_pkg::cmd_t    cmd
);

  grt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grt_pkg::ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.accept    = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.dec_ptr   = 1'b0;
    cmd.out_valid = 1'b0;
    case (state)
      grt_pkg::ST_FILL: begin
        cmd.accept = sts.in_valid;
        if (sts.in_valid && sts.group_done) begin
          state_next = grt_pkg::ST_READ;
        end
      end
      grt_pkg::ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = grt_pkg::ST_SHOW;
      end
      grt_pkg::ST_SHOW: begin
        cmd.out_valid = 1'b1;
        if (sts.out_ready) begin
          if (sts.ptr_zero) begin
            state_next = grt_pkg::ST_FILL;
          end else begin
            cmd.dec_ptr = 1'b1;
            state_next  = grt_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_next = grt_pkg::ST_FILL;
      end
    endcase
  end

endmodule

/* sv/grt_dp.sv */
// Datapath: group store, fill count, drain pointer and output fields.
`timescale 1ns / 1ps

module grt_dp #(
  parameter int MAX_GROUP = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  grt_pkg::cmd_t               cmd,
  input  logic [grt_pkg::SIZE_W-1:0]  group_size,
  input  logic [grt_pkg::DATA_W-1:0]  char_in,
  input  logic                        line_end,
  output logic                        group_done,
  output logic                        ptr_zero,
  output logic [grt_pkg::DATA_W-1:0]  char_out,
  output logic                        line_end_out,
  output logic                        group_last
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [AW-1:0]             fill_count;
  logic [AW-1:0]             rd_ptr;
  logic                      last_flag;
  logic [grt_pkg::CMP_W-1:0] eff_size;
  logic [grt_pkg::CMP_W-1:0] count;

  // zero counts as one, oversize clamps to the store depth
  always_comb begin
    if (group_size == '0) begin
      eff_size = grt_pkg::CMP_W'(1);
    end else if ({1'b0, group_size} > grt_pkg::CMP_W'(MAX_GROUP)) begin
      eff_size = grt_pkg::CMP_W'(MAX_GROUP);
    end else begin
      eff_size = {1'b0, group_size};
    end
  end

  assign count      = grt_pkg::CMP_W'(fill_count) + grt_pkg::CMP_W'(1);
  assign group_done = line_end || (count >= eff_size);
  assign ptr_zero   = (rd_ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.accept) begin
      if (group_done) begin
        fill_count <= '0;
      end else begin
        fill_count <= fill_count + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && group_done) begin
      rd_ptr    <= fill_count;
      last_flag <= line_end;
    end else if (cmd.dec_ptr) begin
      rd_ptr <= rd_ptr - AW'(1);
    end
  end

  grt_ram #(
    .WIDTH (grt_pkg::DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (fill_count),
    .wr_data (char_in),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_ptr),
    .rd_data (char_out)
  );

  assign line_end_out = last_flag && ptr_zero;
  assign group_last   = ptr_zero;

endmodule

/* sv/group_reverse_transposer_core.sv */
// Top level of the group reverse transposer: APB register, controller and datapath.
`timescale 1ns / 1ps

// Characters stream in on in_ch and are collected into groups of group_size
// (APB register at byte address 0, reset 4; 0 acts as 1, values above
// MAX_GROUP act as MAX_GROUP). A group is sent out reversed on out_ch when it
// is full or when line_end marks the last character; group_last flags the
// final character of each group and line_end_out the final one of a line.
// A character that does not close a group is taken in the cycle it is offered.
// A character that closes a group is taken the same way; the group then
// drains character by character, each one read from the group store
// (registered read) and then held on out_ch until ready takes it; no input is
// taken during the drain. Write group_size only while the block is idle.

module group_reverse_transposer_core #(
  parameter int MAX_GROUP = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  grt_in_if.sink      in_ch,
  grt_out_if.source   out_ch
);

  logic [grt_pkg::SIZE_W-1:0] group_size;
  grt_pkg::cmd_t              cmd;
  grt_pkg::status_t           sts;
  logic                       group_done;
  logic                       ptr_zero;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= grt_pkg::GROUP_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == grt_pkg::REG_GROUP_SIZE) begin
      group_size <= pwdata[grt_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == grt_pkg::REG_GROUP_SIZE) begin
      prdata = {{(32 - grt_pkg::SIZE_W){1'b0}}, group_size};
    end else begin
      prdata = '0;
    end
  end

  assign sts.in_valid   = in_ch.valid;
  assign sts.out_ready  = out_ch.ready;
  assign sts.group_done = group_done;
  assign sts.ptr_zero   = ptr_zero;

  grt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  grt_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .group_size   (group_size),
    .char_in      (in_ch.char_in),
    .line_end     (in_ch.line_end),
    .group_done   (group_done),
    .ptr_zero     (ptr_zero),
    .char_out     (out_ch.char_out),
    .line_end_out (out_ch.line_end_out),
    .group_last   (out_ch.group_last)
  );

  assign in_ch.ready  = cmd.accept || (!in_ch.valid && !cmd.rd_en && !cmd.out_valid);
  assign out_ch.valid = cmd.out_valid;

endmodule

/* test/grt_transpose_checker.sv */
// Checker for the group reverse transposer: predicts each reversed group and compares transfers.
`timescale 1ns / 1ps

module grt_transpose_checker
  import grt_pkg::*;
#(
  parameter int MAX_GROUP = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  grt_in_if           in_mon,
  grt_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  typedef struct packed {
    logic [DATA_W-1:0] ch;
    logic              line_end;
    logic              group_end;
  } rev_char_t;

  logic [DATA_W-1:0] group_chars [MAX_GROUP];
  int unsigned       held_count;
  logic [SIZE_W-1:0] group_size_q;
  rev_char_t         reversed_chars [$];
  int unsigned       fail_total = 0;
  int unsigned       queued     = 0;

  assign mismatch_count = fail_total;
  assign pending_count  = queued;

  function automatic int unsigned live_size();
    if (group_size_q == '0) return 1;
    if (group_size_q > MAX_GROUP) return MAX_GROUP;
    return group_size_q;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_total < 100) $display("[%0t] %s", $time, msg);
    fail_total++;
  endtask

  task automatic take_char(input logic [DATA_W-1:0] ch, input logic last);
    int unsigned count;
    rev_char_t   rc;
    group_chars[held_count] = ch;
    count = held_count + 1;
    if (count < live_size() && !last) begin
      held_count = count;
    end else begin
      for (int k = 0; k < count; k++) begin
        rc.ch        = group_chars[count - 1 - k];
        rc.group_end = (k == count - 1);
        rc.line_end  = rc.group_end && last;
        reversed_chars.push_back(rc);
      end
      held_count = 0;
    end
  endtask

  task automatic check_char();
    rev_char_t want;
    if (reversed_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer: char_out %02h line_end_out %0b group_last %0b",
                                out_mon.char_out, out_mon.line_end_out, out_mon.group_last));
      return;
    end
    want = reversed_chars.pop_front();
    if (out_mon.char_out !== want.ch)
      report_mismatch($sformatf("char_out got %02h, want %02h", out_mon.char_out, want.ch));
    if (out_mon.line_end_out !== want.line_end)
      report_mismatch($sformatf("line_end_out got %0b, want %0b (char %02h)",
                                out_mon.line_end_out, want.line_end, want.ch));
    if (out_mon.group_last !== want.group_end)
      report_mismatch($sformatf("group_last got %0b, want %0b (char %02h)",
                                out_mon.group_last, want.group_end, want.ch));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count   = 0;
      group_size_q = GROUP_SIZE_RESET;
      reversed_chars.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) take_char(in_mon.char_in, in_mon.line_end);
      if (out_mon.valid && out_mon.ready) check_char();
      if (psel && penable && pwrite && pready && paddr[2] == REG_GROUP_SIZE)
        group_size_q = pwdata[SIZE_W-1:0];
    end
    queued = reversed_chars.size();
  end

endmodule

/* test/tb_group_reverse_transposer_core.sv */
// Testbench top for the group reverse transposer: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_group_reverse_transposer_core;
  import grt_pkg::*;

  localparam int          MAX_GROUP       = 32;
  localparam logic [2:0]  GROUP_SIZE_ADDR = {REG_GROUP_SIZE, 2'b00};
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned IDLE_CYCLES     = 8;
  localparam int unsigned SETTLE_CYCLES   = 2 * MAX_GROUP + 8;
  localparam int unsigned PHASE_SIZES [9] = '{2, 1, 7, 32, 3, 63, 16, 0, 5};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        in_idle_on;
  logic        out_idle_on;
  logic        hold_request;
  logic        hold_off;
  int unsigned cycle_count = 0;
  int unsigned mismatches;
  int unsigned pending;

  grt_in_if  in_ch ();
  grt_out_if out_ch ();

  group_reverse_transposer_core #(.MAX_GROUP(MAX_GROUP)) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  grt_transpose_checker #(.MAX_GROUP(MAX_GROUP)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (out_idle_on) out_ch.ready <= ($urandom_range(99) >= 37);
      else out_ch.ready <= 1'b1;
    end
  end

  // hold off the receiver while the sender keeps offering characters
  initial begin
    hold_off = 1'b0;
    wait (hold_request);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (200) @(negedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_char(input logic [DATA_W-1:0] ch, input logic last);
    while (in_idle_on && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.char_in  <= ch;
    in_ch.line_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_run(input int unsigned len, input logic close);
    for (int unsigned i = 0; i < len; i++)
      send_char(DATA_W'($urandom_range(255)), close && (i == len - 1));
  endtask

  task automatic write_group_size(input logic [31:0] value);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GROUP_SIZE_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [31:0] size_word;
    int unsigned lim;
    int unsigned budget;
    int unsigned done_chars;
    int unsigned len;
    logic        close;

    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.char_in  = '0;
    in_ch.line_end = 1'b0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    hold_request   = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset size: one full group, then two short groups closed by line_end
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h42, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h01, 1'b1);
    send_char(8'h5A, 1'b1);

    // zero acts as one
    write_group_size(32'd0);
    send_char(8'hAA, 1'b0);
    send_char(8'h55, 1'b1);

    write_group_size(32'd1);
    send_char(8'h33, 1'b0);
    send_char(8'hCC, 1'b1);

    // lower the size while characters are held
    write_group_size(32'd8);
    send_run(5, 1'b0);
    write_group_size(32'd3);
    send_run(2, 1'b1);

    write_group_size(32'd63);
    send_run(3, 1'b1);

    for (int p = 0; p < 11; p++) begin
      if (p < 9) size_word = PHASE_SIZES[p];
      else size_word = $urandom();
      write_group_size(size_word);
      if (size_word[SIZE_W-1:0] == '0) lim = 1;
      else if (size_word[SIZE_W-1:0] > MAX_GROUP) lim = MAX_GROUP;
      else lim = size_word[SIZE_W-1:0];
      budget = (lim >= 16) ? 36 : 16;
      if (p == 0) hold_request <= 1'b1;
      if (p == 3) begin
        in_idle_on  <= 1'b0;
        out_idle_on <= 1'b0;
      end
      if (p == 4) begin
        in_idle_on  <= 1'b1;
        out_idle_on <= 1'b1;
      end
      done_chars = 0;
      while (done_chars < budget) begin
        len = ($urandom_range(7) == 0) ? 1 : $urandom_range(1, 2 * lim + 2);
        if (len > budget - done_chars) len = budget - done_chars;
        close = (done_chars + len < budget) || ($urandom_range(3) != 0);
        send_run(len, close);
        done_chars += len;
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
